// File: hw/rtl/i8080alu_pkg.sv
// Package for the 8080 ALU and flags unit: operation codes, the flag record
// and the sign/zero/parity helper and PSW flag-byte packer. No dependencies.
`default_nettype none

package i8080alu_pkg;

  // Operation codes carried in the operation field.
  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBB = 5'd3,
    OP_ANA = 5'd4,
    OP_XRA = 5'd5,
    OP_ORA = 5'd6,
    OP_CMP = 5'd7,
    OP_INR = 5'd8,
    OP_DCR = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RAL = 5'd12,
    OP_RAR = 5'd13,
    OP_CMA = 5'd14,
    OP_STC = 5'd15,
    OP_CMC = 5'd16,
    OP_LDF = 5'd17
  } alu_op_t;

  // The five flags kept between operations.
  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  // Sign, zero and even parity of a result byte; AC and CY come back clear.
  function automatic flags_t szp_of(input logic [7:0] v);
    flags_t f;
    f    = '0;
    f.s  = v[7];
    f.z  = (v == 8'h00);
    f.p  = ~^v;
    return f;
  endfunction

  // Flags in the PSW layout: S Z 0 AC 0 P 1 CY.
  function automatic logic [7:0] pack_flags(input flags_t f);
    return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/i8080_alu_and_flags_unit.sv
// Top level of the 8080 ALU and flags unit: input register, one pass of
// arithmetic and flag logic, result register. Depends on i8080alu_pkg.
`default_nettype none

// The unit takes one operation per clock and returns one result per
// operation, in order. A transfer on the input channel lands in an input
// register; once the output register is free or being taken, the ALU and
// flag logic work on it and the result is written to the output register,
// where it is held until it is taken. The flag register is updated at the
// same edge the result is registered, which lets each operation see the
// flags left by the one before it with no extra wait.
// Throughput is one item per cycle as long as the output side does not stall;
// a stall on the output holds the result and, once the input register is
// full, stalls the input.
module i8080_alu_and_flags_unit
  import i8080alu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] in_operation,
  input  wire logic [7:0] in_acc_value,
  input  wire logic [7:0] in_operand_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_result_value,
  output logic [7:0]      out_flag_byte
);

  logic       s1_valid_r;
  logic [4:0] s1_op_r;
  logic [7:0] s1_a_r;
  logic [7:0] s1_b_r;

  logic       out_valid_r;
  logic [7:0] result_r;
  logic [7:0] flag_byte_r;
  flags_t     flags_r;

  logic       advance;
  logic       in_xfer;
  logic [7:0] result_nxt;
  flags_t     flags_nxt;

  // The stage moves forward when the output register is empty or being taken.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_xfer) begin
      s1_op_r <= in_operation;
      s1_a_r  <= in_acc_value;
      s1_b_r  <= in_operand_value;
    end
  end

  // ALU and flag logic for the item in the input register.
  always_comb begin
    logic       sub;
    logic       cin;
    logic [7:0] bsel;
    logic [8:0] sum;
    logic [4:0] low_sum;
    flags_t     arith;

    // Shared adder: subtraction adds the complement with an inverted borrow.
    sub     = (s1_op_r == OP_SUB) || (s1_op_r == OP_SBB) || (s1_op_r == OP_CMP);
    bsel    = sub ? ~s1_b_r : s1_b_r;
    case (s1_op_r)
      OP_ADC:  cin = flags_r.cy;
      OP_SBB:  cin = ~flags_r.cy;
      OP_SUB:  cin = 1'b1;
      OP_CMP:  cin = 1'b1;
      default: cin = 1'b0;
    endcase
    sum      = {1'b0, s1_a_r} + {1'b0, bsel} + {8'h00, cin};
    low_sum  = {1'b0, s1_a_r[3:0]} + {1'b0, bsel[3:0]} + {4'h0, cin};
    arith    = szp_of(sum[7:0]);
    arith.ac = low_sum[4];
    arith.cy = sum[8] ^ sub;

    result_nxt = s1_a_r;
    flags_nxt  = flags_r;
    case (s1_op_r)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
        result_nxt = sum[7:0];
        flags_nxt  = arith;
      end
      OP_CMP: begin
        flags_nxt = arith;
      end
      OP_ANA: begin
        result_nxt   = s1_a_r & s1_b_r;
        flags_nxt    = szp_of(result_nxt);
        flags_nxt.ac = s1_a_r[3] | s1_b_r[3];
      end
      OP_XRA: begin
        result_nxt = s1_a_r ^ s1_b_r;
        flags_nxt  = szp_of(result_nxt);
      end
      OP_ORA: begin
        result_nxt = s1_a_r | s1_b_r;
        flags_nxt  = szp_of(result_nxt);
      end
      OP_INR: begin
        result_nxt   = s1_b_r + 8'h01;
        flags_nxt    = szp_of(result_nxt);
        flags_nxt.cy = flags_r.cy;
        flags_nxt.ac = (result_nxt[3:0] == 4'h0);
      end
      OP_DCR: begin
        result_nxt   = s1_b_r - 8'h01;
        flags_nxt    = szp_of(result_nxt);
        flags_nxt.cy = flags_r.cy;
        flags_nxt.ac = (result_nxt[3:0] != 4'hF);
      end
      OP_RLC: begin
        result_nxt   = {s1_a_r[6:0], s1_a_r[7]};
        flags_nxt.cy = s1_a_r[7];
      end
      OP_RRC: begin
        result_nxt   = {s1_a_r[0], s1_a_r[7:1]};
        flags_nxt.cy = s1_a_r[0];
      end
      OP_RAL: begin
        result_nxt   = {s1_a_r[6:0], flags_r.cy};
        flags_nxt.cy = s1_a_r[7];
      end
      OP_RAR: begin
        result_nxt   = {flags_r.cy, s1_a_r[7:1]};
        flags_nxt.cy = s1_a_r[0];
      end
      OP_CMA: begin
        result_nxt = ~s1_a_r;
      end
      OP_STC: begin
        flags_nxt.cy = 1'b1;
      end
      OP_CMC: begin
        flags_nxt.cy = ~flags_r.cy;
      end
      OP_LDF: begin
        flags_nxt.s  = s1_b_r[7];
        flags_nxt.z  = s1_b_r[6];
        flags_nxt.ac = s1_b_r[4];
        flags_nxt.p  = s1_b_r[2];
        flags_nxt.cy = s1_b_r[0];
      end
      default: begin
        // Unused codes pass the accumulator and keep the flags.
        result_nxt = s1_a_r;
        flags_nxt  = flags_r;
      end
    endcase
  end

  // Flag register and result register, written together on each transfer out
  // of the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      result_r    <= result_nxt;
      flag_byte_r <= pack_flags(flags_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;
  assign out_flag_byte    = flag_byte_r;

  // The shown flag byte always matches the kept flags after a transfer.
  a_flag_byte_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_flag_byte == pack_flags(flags_r)))
    else $error("flag byte does not match flag register");

  // Flags change only when an item leaves the input stage.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("flags changed without a transfer");

  // A compare leaves the accumulator unchanged in the result.
  a_cmp_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_op_r == OP_CMP)) |=> (out_result_value == $past(s1_a_r)))
    else $error("compare altered the result byte");

  // The input side only stalls while a pending item is blocked by the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked output");

endmodule

`default_nettype wire
